[rtl/sample_histogram_bar_scaler_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sample histogram bar scaler
// Concurrent property shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef SAMPLE_HISTOGRAM_BAR_SCALER_DEFINES_SVH
`define SAMPLE_HISTOGRAM_BAR_SCALER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define SHBS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("shbs assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define SHBS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("shbs assertion failed");

`endif

[rtl/shbs_pkg.sv]
// ----------------------------------------------------------------------------
// Sample histogram bar scaler package
// Shared widths, opcodes, back-end states and defaults.
// ----------------------------------------------------------------------------
package shbs_pkg;

  // Fixed field widths
  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned OUT_W    = 16;
  localparam int unsigned FS_W     = 16;

  // Parameter defaults
  localparam int unsigned BINS_DEF       = 4096;
  localparam int unsigned COUNT_BITS_DEF = 16;

  // Command queue depth between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Fixed-point shift of the reciprocal used for bin wrapping
  localparam int unsigned RECIP_SHIFT = 24;

  // Reset value of the full scale register
  localparam logic [FS_W-1:0] FULL_SCALE_RST = 16'd159;

  typedef enum logic [OPCODE_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_FETCH,
    ST_CALC,
    ST_DIV,
    ST_OUT
  } back_state_e;

endpackage

[rtl/shbs_intf.sv]
// ----------------------------------------------------------------------------
// Sample histogram bar scaler channels
// Valid/ready interfaces for the item, result and configuration channels.
// ----------------------------------------------------------------------------

// Input item channel
interface shbs_in_if import shbs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [SAMPLE_W-1:0] sample;
  logic [SAMPLE_W-1:0] read_bin;

  modport source (output valid, opcode, sample, read_bin, input ready);
  modport sink   (input valid, opcode, sample, read_bin, output ready);
endinterface

// Result channel
interface shbs_out_if import shbs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] bin_count;
  logic [OUT_W-1:0] peak_count;
  logic [OUT_W-1:0] bar_height;

  modport source (output valid, bin_count, peak_count, bar_height, input ready);
  modport sink   (input valid, bin_count, peak_count, bar_height, output ready);
endinterface

// Configuration write channel
interface shbs_cfg_if import shbs_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [FS_W-1:0] full_scale;

  modport source (output valid, full_scale, input ready);
  modport sink   (input valid, full_scale, output ready);
endinterface

[rtl/shbs_front.sv]
// ----------------------------------------------------------------------------
// Sample histogram front end
// Accepts items, picks the bin index by opcode and wraps it into range.
// ----------------------------------------------------------------------------
module shbs_front import shbs_pkg::*; #(
  parameter int unsigned BINS = BINS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  hold_i,
  shbs_in_if.sink                               in_i,
  input  logic                                  q_full_i,
  output logic                                  q_push_o,
  output logic [OPCODE_W+$clog2(BINS)-1:0]      q_data_o
);

  localparam int unsigned IDX_W   = $clog2(BINS);
  localparam int unsigned RECIP_W = RECIP_SHIFT - $clog2(BINS) + 1;
  localparam int unsigned PROD_W  = RECIP_SHIFT + SAMPLE_W;
  localparam int unsigned QB_W    = SAMPLE_W + IDX_W + 1;
  localparam int unsigned RW      = ((IDX_W > SAMPLE_W) ? IDX_W : SAMPLE_W) + 1;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / BINS);

  opcode_e             in_op;
  logic [SAMPLE_W-1:0] raw;
  logic [PROD_W-1:0]   prod;
  logic                accept;

  logic                s1_valid_q;
  opcode_e             s1_op_q;
  logic [SAMPLE_W-1:0] s1_raw_q;
  logic [SAMPLE_W-1:0] s1_quo_q;

  logic [QB_W-1:0]     qb;
  logic [SAMPLE_W-1:0] diff;
  logic [RW-1:0]       diff_x;
  logic [RW-1:0]       rem;

  // Stall on a full queue, and hold off entirely during the reset sweep
  assign in_i.ready = !hold_i && (!s1_valid_q || !q_full_i);
  assign accept     = in_i.valid && in_i.ready;
  assign q_push_o   = s1_valid_q && !q_full_i;

  // Select the raw index by opcode
  assign in_op = opcode_e'(in_i.opcode);
  always_comb begin
    unique case (in_op)
      OP_ADD:          raw = in_i.sample;
      OP_READ:         raw = in_i.read_bin;
      OP_CLEAR, OP_NOP: raw = '0;
      default:         raw = '0;
    endcase
  end

  // Estimate the quotient by the bin count via a fixed-point reciprocal
  assign prod = PROD_W'(raw) * PROD_W'(RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (q_push_o) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q  <= in_op;
      s1_raw_q <= raw;
      s1_quo_q <= prod[PROD_W-1 -: SAMPLE_W];
    end
  end

  // Remainder: estimate is low by at most one, so one correction step
  assign qb     = QB_W'(s1_quo_q) * QB_W'(BINS);
  assign diff   = s1_raw_q - qb[SAMPLE_W-1:0];
  assign diff_x = RW'(diff);
  assign rem    = (diff_x >= RW'(BINS)) ? diff_x - RW'(BINS) : diff_x;

  assign q_data_o = {s1_op_q, rem[IDX_W-1:0]};

endmodule

[rtl/shbs_fifo.sv]
// ----------------------------------------------------------------------------
// Sample histogram command queue
// Short first-in first-out queue between the front and back ends.
// ----------------------------------------------------------------------------
module shbs_fifo import shbs_pkg::*; #(
  parameter int unsigned WIDTH = OPCODE_W + $clog2(BINS_DEF),
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_FULL);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[rtl/shbs_div.sv]
// ----------------------------------------------------------------------------
// Sample histogram bar divider
// Restoring divider, one quotient bit per cycle, 16-bit quotient.
// ----------------------------------------------------------------------------
module shbs_div import shbs_pkg::*; #(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [COUNT_BITS+FS_W-1:0] num_i,
  input  logic [COUNT_BITS-1:0]      den_i,
  output logic                       busy_o,
  output logic [FS_W-1:0]            quot_o
);

  // The quotient is known to fit FS_W bits, so the upper numerator bits
  // start out as a partial remainder already below the divisor.
  localparam int unsigned NUM_W  = COUNT_BITS + FS_W;
  localparam int unsigned STEP_W = $clog2(FS_W);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(FS_W - 1);

  logic [COUNT_BITS-1:0] rem_q, den_q;
  logic [FS_W-1:0]       sh_q;
  logic [STEP_W-1:0]     step_q;
  logic                  busy_q;
  logic [COUNT_BITS:0]   trial;
  logic                  ge;

  assign trial  = {rem_q, sh_q[FS_W-1]};
  assign ge     = (trial >= {1'b0, den_q});
  assign busy_o = busy_q;
  assign quot_o = sh_q;

  // Sequence the iterations
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + 1'b1;
      if (step_q == STEP_LAST) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Shift in numerator bits, shift out quotient bits
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i[NUM_W-1 -: COUNT_BITS];
      sh_q  <= num_i[FS_W-1:0];
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? COUNT_BITS'(trial - {1'b0, den_q}) : trial[COUNT_BITS-1:0];
      sh_q  <= {sh_q[FS_W-2:0], ge};
    end
  end

endmodule

[rtl/shbs_back.sv]
// ----------------------------------------------------------------------------
// Sample histogram back end
// Owns the bin memory and peak; runs clears, updates, reads and scaling.
// ----------------------------------------------------------------------------
module shbs_back import shbs_pkg::*; #(
  parameter int unsigned BINS       = BINS_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [FS_W-1:0]                  full_scale_i,
  input  logic                             q_empty_i,
  input  logic [OPCODE_W+$clog2(BINS)-1:0] q_data_i,
  output logic                             q_pop_o,
  output logic                             init_busy_o,
  shbs_out_if.source                       out_o
);

  localparam int unsigned IDX_W = $clog2(BINS);
  localparam int unsigned CMD_W = OPCODE_W + IDX_W;
  localparam int unsigned NUM_W = COUNT_BITS + FS_W;
  localparam logic [IDX_W-1:0]      LAST_IDX  = IDX_W'(BINS - 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  back_state_e state_q, state_d;

  // Control state
  logic [IDX_W-1:0]      clr_q;
  logic                  emit_q;
  logic                  init_q;
  logic [COUNT_BITS-1:0] peak_q;
  logic                  out_valid_q;

  // Payload state
  opcode_e               op_q;
  logic [IDX_W-1:0]      idx_q;
  logic [COUNT_BITS-1:0] rd_q;
  logic [COUNT_BITS-1:0] cnt_q;
  logic [FS_W-1:0]       bar_q;
  logic                  zero_q;
  logic [OUT_W-1:0]      out_cnt_q, out_peak_q, out_bar_q;

  logic [COUNT_BITS-1:0] bin_mem [BINS];

  // Decode and control
  opcode_e               head_op;
  logic [IDX_W-1:0]      head_idx;
  logic                  out_free;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;
  logic [COUNT_BITS-1:0] inc_cnt, new_cnt;
  logic                  div_start, div_busy, out_load;
  logic [FS_W-1:0]       div_quot;
  logic [NUM_W-1:0]      num;

  assign head_op  = opcode_e'(q_data_i[CMD_W-1 -: OPCODE_W]);
  assign head_idx = q_data_i[IDX_W-1:0];
  assign out_free = !out_valid_q || out_o.ready;
  assign inc_cnt  = (rd_q == COUNT_MAX) ? rd_q : rd_q + 1'b1;
  assign new_cnt  = (op_q == OP_ADD) ? inc_cnt : rd_q;
  assign num      = NUM_W'(cnt_q) * NUM_W'(full_scale_i);

  assign init_busy_o      = init_q;
  assign out_o.valid      = out_valid_q;
  assign out_o.bin_count  = out_cnt_q;
  assign out_o.peak_count = out_peak_q;
  assign out_o.bar_height = out_bar_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_SWEEP: begin
        if (clr_q == LAST_IDX) begin
          state_d = emit_q ? ST_OUT : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_empty_i) begin
          unique case (head_op)
            OP_CLEAR:        state_d = ST_SWEEP;
            OP_ADD, OP_READ: state_d = ST_FETCH;
            OP_NOP:          state_d = ST_OUT;
            default:         state_d = ST_OUT;
          endcase
        end
      end
      ST_FETCH: state_d = ST_CALC;
      ST_CALC: begin
        state_d = ((cnt_q == '0) || (peak_q == '0)) ? ST_OUT : ST_DIV;
      end
      ST_DIV: begin
        if (!div_busy) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    q_pop_o   = (state_q == ST_IDLE) && !q_empty_i;
    mem_we    = (state_q == ST_SWEEP) || ((state_q == ST_FETCH) && (op_q == OP_ADD));
    mem_waddr = (state_q == ST_SWEEP) ? clr_q : idx_q;
    mem_wdata = (state_q == ST_SWEEP) ? '0 : inc_cnt;
    div_start = (state_q == ST_CALC) && (cnt_q != '0) && (peak_q != '0);
    out_load  = (state_q == ST_OUT) && out_free;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SWEEP;
      clr_q       <= '0;
      emit_q      <= 1'b0;
      init_q      <= 1'b1;
      peak_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_SWEEP) begin
        clr_q <= clr_q + 1'b1;
        if (clr_q == LAST_IDX) begin
          init_q <= 1'b0;
        end
      end
      if (q_pop_o && (head_op == OP_CLEAR)) begin
        clr_q  <= '0;
        emit_q <= 1'b1;
        peak_q <= '0;
      end
      if ((state_q == ST_FETCH) && (new_cnt > peak_q)) begin
        peak_q <= new_cnt;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      op_q   <= head_op;
      idx_q  <= head_idx;
      zero_q <= (head_op == OP_CLEAR) || (head_op == OP_NOP);
    end
    if (state_q == ST_FETCH) begin
      cnt_q <= new_cnt;
    end
    if (state_q == ST_CALC) begin
      bar_q <= '0;
    end else if ((state_q == ST_DIV) && !div_busy) begin
      bar_q <= div_quot;
    end
    if (out_load) begin
      out_cnt_q  <= zero_q ? '0 : OUT_W'(cnt_q);
      out_peak_q <= zero_q ? '0 : OUT_W'(peak_q);
      out_bar_q  <= zero_q ? '0 : OUT_W'(bar_q);
    end
  end

  // Bin memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      bin_mem[mem_waddr] <= mem_wdata;
    end
    if (q_pop_o) begin
      rd_q <= bin_mem[head_idx];
    end
  end

  shbs_div #(
    .COUNT_BITS (COUNT_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   (peak_q),
    .busy_o  (div_busy),
    .quot_o  (div_quot)
  );

endmodule

[rtl/sample_histogram_bar_scaler.sv]
// ----------------------------------------------------------------------------
// Sample histogram bar scaler
// Histogram of 12-bit samples with saturating bins, running peak and
// bar-height scaling of a bin count against the peak.
// ----------------------------------------------------------------------------
//  channel  dir  beat
//  in_i     in   opcode, sample, read_bin
//  out_o    out  bin_count, peak_count, bar_height
//  cfg_i    in   full_scale (always ready)
//
//  Add and read take the back end through memory read, update, multiply,
//  the divider steps, taking the quotient and output load; a zero count
//  skips the divider. Clear zeroes the bins, one bin per cycle. After
//  reset a clearing pass runs with in_i.ready low. A front stage and a
//  two-entry queue keep accepting while the back end works or out_o stalls.
// ----------------------------------------------------------------------------
module sample_histogram_bar_scaler import shbs_pkg::*; #(
  parameter int unsigned BINS       = BINS_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  shbs_in_if.sink     in_i,
  shbs_out_if.source  out_o,
  shbs_cfg_if.sink    cfg_i
);

  localparam int unsigned CMD_W = OPCODE_W + $clog2(BINS);

  logic [FS_W-1:0]  full_scale_q;
  logic             q_full, q_empty, q_push, q_pop, init_busy;
  logic [CMD_W-1:0] q_wdata, q_rdata;

  // Configuration register
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_scale_q <= FULL_SCALE_RST;
    end else if (cfg_i.valid) begin
      full_scale_q <= cfg_i.full_scale;
    end
  end

  shbs_front #(
    .BINS (BINS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .hold_i   (init_busy),
    .in_i     (in_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_data_o (q_wdata)
  );

  shbs_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_rdata)
  );

  shbs_back #(
    .BINS       (BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .full_scale_i (full_scale_q),
    .q_empty_i    (q_empty),
    .q_data_i     (q_rdata),
    .q_pop_o      (q_pop),
    .init_busy_o  (init_busy),
    .out_o        (out_o)
  );

endmodule

[rtl/shbs_checker.sv]
// ----------------------------------------------------------------------------
// Sample histogram bar scaler port checker
// Watches the top-level ports for result hand-off and reset behavior.
// ----------------------------------------------------------------------------
`include "sample_histogram_bar_scaler_defines.svh"

module shbs_checker import shbs_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_ready_i,
  input logic             cfg_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [OUT_W-1:0] bin_count_i,
  input logic [OUT_W-1:0] peak_count_i,
  input logic [OUT_W-1:0] bar_height_i
);

  // Hold a stalled result beat
  `SHBS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)

  // Keep a stalled result payload steady
  `SHBS_ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(bin_count_i) && $stable(peak_count_i) && $stable(bar_height_i))

  // Drop input ready in the first cycle after reset: the clearing pass runs
  `SHBS_ASSERT_IMP(a_sweep_after_reset, clk_i, rst_ni, $past(rst_ni) == 1'b0, !in_ready_i)

  // Never stall configuration writes
  `SHBS_ASSERT_IMP(a_cfg_ready, clk_i, rst_ni, 1'b1, cfg_ready_i)

endmodule

bind sample_histogram_bar_scaler shbs_checker u_shbs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (in_i.ready),
  .cfg_ready_i  (cfg_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .bin_count_i  (out_o.bin_count),
  .peak_count_i (out_o.peak_count),
  .bar_height_i (out_o.bar_height)
);
